FILE: hw/rtl/mau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mau_pkg;

  localparam int VALUE_BITS = 31;
  localparam int A_BITS     = 31;
  localparam int B_BITS     = 64;
  localparam int ACT_BITS   = 3;
  localparam int CNT_BITS   = $clog2(B_BITS);

  typedef logic [VALUE_BITS-1:0] res_t;

  localparam res_t MODULUS_RESET = VALUE_BITS'(998244353);

  typedef enum logic [ACT_BITS-1:0] {
    ACT_ADD = 3'd0,
    ACT_SUB = 3'd1,
    ACT_MUL = 3'd2,
    ACT_DIV = 3'd3,
    ACT_POW = 3'd4
  } act_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED_A,
    ST_LOAD_B,
    ST_RED_B,
    ST_FIX_B,
    ST_DISPATCH,
    ST_DIV,
    ST_LOAD_Q,
    ST_MUL,
    ST_MUL_END,
    ST_INV_UPD,
    ST_POW
  } state_t;

  // Where a modular multiply hands its product when it finishes.
  typedef enum logic [1:0] {
    MR_RESULT,
    MR_INV,
    MR_POW_RET,
    MR_POW_SQ
  } mret_t;

  typedef struct packed {
    res_t acc;
    res_t y;
    logic feed;
    res_t divisor;
  } step_in_t;

  typedef struct packed {
    res_t rem;
    logic qbit;
  } step_out_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mau_step.sv
`timescale 1ns / 1ps
`default_nettype none

// One step of shift-and-reduce: rem = (2*acc + (feed ? y : 0)) mod divisor.
// With acc and y below the divisor the sum stays below three divisors.
module mau_step (
  input  wire mau_pkg::step_in_t si,
  output mau_pkg::step_out_t     so
);

  logic [mau_pkg::VALUE_BITS+1:0] sum_w;
  logic [mau_pkg::VALUE_BITS+1:0] d1_w;
  logic [mau_pkg::VALUE_BITS+1:0] d2_w;
  logic [mau_pkg::VALUE_BITS+1:0] rem_w;

  assign sum_w = {1'b0, si.acc, 1'b0} + (si.feed ? {2'b00, si.y} : '0);
  assign d1_w  = {2'b00, si.divisor};
  assign d2_w  = {1'b0, si.divisor, 1'b0};

  always_comb begin
    if (sum_w >= d2_w) begin
      rem_w = sum_w - d2_w;
    end else if (sum_w >= d1_w) begin
      rem_w = sum_w - d1_w;
    end else begin
      rem_w = sum_w;
    end
  end

  assign so.rem  = rem_w[mau_pkg::VALUE_BITS-1:0];
  assign so.qbit = (sum_w >= d1_w);

endmodule

`default_nettype wire

FILE: hw/rtl/mau_core.sv
`timescale 1ns / 1ps
`default_nettype none

module mau_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [mau_pkg::ACT_BITS-1:0] in_action,
  input  wire logic [mau_pkg::A_BITS-1:0]   in_operand_a,
  input  wire logic [mau_pkg::B_BITS-1:0]   in_operand_b,
  input  wire mau_pkg::res_t                modulus,
  output logic                              out_valid,
  output mau_pkg::res_t                     out_result
);

  localparam int VB = mau_pkg::VALUE_BITS;
  localparam int BB = mau_pkg::B_BITS;
  localparam int CB = mau_pkg::CNT_BITS;

  mau_pkg::state_t state_r, state_nxt;
  mau_pkg::mret_t  mret_r, mret_nxt;

  logic [CB-1:0]                    cnt_r, cnt_nxt;
  logic [BB-1:0]                    sh_r, sh_nxt;
  logic [BB-1:0]                    b_r, b_nxt;
  logic [mau_pkg::ACT_BITS-1:0]     op_r, op_nxt;
  mau_pkg::res_t                    acc_r, acc_nxt;
  mau_pkg::res_t                    y_r, y_nxt;
  mau_pkg::res_t                    ra_r, ra_nxt;
  mau_pkg::res_t                    rb_r, rb_nxt;
  mau_pkg::res_t                    eb_r, eb_nxt;
  mau_pkg::res_t                    eu_r, eu_nxt;
  mau_pkg::res_t                    ev_r, ev_nxt;
  mau_pkg::res_t                    rem_r, rem_nxt;
  mau_pkg::res_t                    pret_r, pret_nxt;
  mau_pkg::res_t                    pmul_r, pmul_nxt;
  logic                             out_valid_r, out_valid_nxt;
  mau_pkg::res_t                    out_result_r, out_result_nxt;

  mau_pkg::step_in_t  step_in;
  mau_pkg::step_out_t step_out;

  logic          last_a;
  logic          last_b;
  logic          last_v;
  logic          bneg;
  mau_pkg::res_t one_mod;

  function automatic mau_pkg::res_t add_mod(mau_pkg::res_t x, mau_pkg::res_t y,
                                             mau_pkg::res_t m);
    logic [mau_pkg::VALUE_BITS:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[mau_pkg::VALUE_BITS-1:0];
  endfunction

  assign last_a  = (cnt_r == CB'(mau_pkg::A_BITS - 1));
  assign last_b  = (cnt_r == CB'(BB - 1));
  assign last_v  = (cnt_r == CB'(VB - 1));
  assign bneg    = b_r[BB-1];
  assign one_mod = (modulus == mau_pkg::res_t'(1)) ? '0 : mau_pkg::res_t'(1);

  // The single shared reduce step; only Euclid's division divides by eb_r.
  assign step_in.acc     = acc_r;
  assign step_in.y       = y_r;
  assign step_in.feed    = sh_r[BB-1];
  assign step_in.divisor = (state_r == mau_pkg::ST_DIV) ? eb_r : modulus;

  mau_step u_step (
    .si (step_in),
    .so (step_out)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mau_pkg::ST_IDLE: begin
        if (start && (modulus != '0)) begin
          state_nxt = mau_pkg::ST_RED_A;
        end
      end
      mau_pkg::ST_RED_A: begin
        if (last_a) begin
          state_nxt = mau_pkg::ST_LOAD_B;
        end
      end
      mau_pkg::ST_LOAD_B:   state_nxt = mau_pkg::ST_RED_B;
      mau_pkg::ST_RED_B: begin
        if (last_b) begin
          state_nxt = mau_pkg::ST_FIX_B;
        end
      end
      mau_pkg::ST_FIX_B:    state_nxt = mau_pkg::ST_DISPATCH;
      mau_pkg::ST_DISPATCH: begin
        case (op_r)
          mau_pkg::ACT_MUL: state_nxt = mau_pkg::ST_MUL;
          mau_pkg::ACT_DIV: state_nxt = mau_pkg::ST_DIV;
          mau_pkg::ACT_POW: state_nxt = bneg ? mau_pkg::ST_IDLE : mau_pkg::ST_POW;
          default:          state_nxt = mau_pkg::ST_IDLE;
        endcase
      end
      mau_pkg::ST_DIV: begin
        if (last_v) begin
          state_nxt = mau_pkg::ST_LOAD_Q;
        end
      end
      mau_pkg::ST_LOAD_Q:   state_nxt = mau_pkg::ST_MUL;
      mau_pkg::ST_MUL: begin
        if (last_v) begin
          state_nxt = mau_pkg::ST_MUL_END;
        end
      end
      mau_pkg::ST_MUL_END: begin
        case (mret_r)
          mau_pkg::MR_RESULT:  state_nxt = mau_pkg::ST_IDLE;
          mau_pkg::MR_INV:     state_nxt = mau_pkg::ST_INV_UPD;
          mau_pkg::MR_POW_RET: state_nxt = mau_pkg::ST_MUL;
          mau_pkg::MR_POW_SQ:  state_nxt = mau_pkg::ST_POW;
          default:             state_nxt = mau_pkg::ST_IDLE;
        endcase
      end
      mau_pkg::ST_INV_UPD: begin
        state_nxt = (rem_r == '0) ? mau_pkg::ST_MUL : mau_pkg::ST_DIV;
      end
      mau_pkg::ST_POW: begin
        state_nxt = (b_r == '0) ? mau_pkg::ST_IDLE : mau_pkg::ST_MUL;
      end
      default: state_nxt = mau_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    mau_pkg::res_t p_inv;

    p_inv          = '0;
    mret_nxt       = mret_r;
    cnt_nxt        = cnt_r;
    sh_nxt         = sh_r;
    b_nxt          = b_r;
    op_nxt         = op_r;
    acc_nxt        = acc_r;
    y_nxt          = y_r;
    ra_nxt         = ra_r;
    rb_nxt         = rb_r;
    eb_nxt         = eb_r;
    eu_nxt         = eu_r;
    ev_nxt         = ev_r;
    rem_nxt        = rem_r;
    pret_nxt       = pret_r;
    pmul_nxt       = pmul_r;
    out_valid_nxt  = 1'b0;
    out_result_nxt = out_result_r;

    case (state_r)
      mau_pkg::ST_IDLE: begin
        if (start) begin
          op_nxt  = in_action;
          b_nxt   = in_operand_b;
          sh_nxt  = {in_operand_a, {(BB - mau_pkg::A_BITS){1'b0}}};
          acc_nxt = '0;
          cnt_nxt = '0;
          y_nxt   = mau_pkg::res_t'(1);
          if (modulus == '0) begin
            out_valid_nxt  = 1'b1;
            out_result_nxt = '0;
          end
        end
      end
      mau_pkg::ST_RED_A, mau_pkg::ST_RED_B, mau_pkg::ST_MUL: begin
        acc_nxt = step_out.rem;
        sh_nxt  = {sh_r[BB-2:0], 1'b0};
        cnt_nxt = cnt_r + CB'(1);
      end
      mau_pkg::ST_LOAD_B: begin
        ra_nxt  = acc_r;
        sh_nxt  = bneg ? ((~b_r) + BB'(1)) : b_r;
        acc_nxt = '0;
        cnt_nxt = '0;
      end
      mau_pkg::ST_FIX_B: begin
        rb_nxt = (bneg && (acc_r != '0)) ? (modulus - acc_r) : acc_r;
      end
      mau_pkg::ST_DISPATCH: begin
        acc_nxt = '0;
        cnt_nxt = '0;
        case (op_r)
          mau_pkg::ACT_ADD: begin
            out_valid_nxt  = 1'b1;
            out_result_nxt = add_mod(ra_r, rb_r, modulus);
          end
          mau_pkg::ACT_SUB: begin
            out_valid_nxt  = 1'b1;
            out_result_nxt = add_mod(ra_r, modulus - rb_r, modulus);
          end
          mau_pkg::ACT_MUL: begin
            sh_nxt   = {ra_r, {(BB - VB){1'b0}}};
            y_nxt    = rb_r;
            mret_nxt = mau_pkg::MR_RESULT;
          end
          mau_pkg::ACT_DIV: begin
            // Euclid starts from (b, modulus) with u = 1 and v = 0, kept mod m.
            sh_nxt = {rb_r, {(BB - VB){1'b0}}};
            eb_nxt = modulus;
            eu_nxt = one_mod;
            ev_nxt = '0;
            y_nxt  = mau_pkg::res_t'(1);
          end
          mau_pkg::ACT_POW: begin
            if (bneg) begin
              out_valid_nxt  = 1'b1;
              out_result_nxt = one_mod;
            end
            pret_nxt = one_mod;
            pmul_nxt = ra_r;
          end
          default: begin
            out_valid_nxt  = 1'b1;
            out_result_nxt = ra_r;
          end
        endcase
      end
      mau_pkg::ST_DIV: begin
        // Restoring division: quotient bits enter sh_r from the bottom.
        acc_nxt = step_out.rem;
        sh_nxt  = {sh_r[BB-2:0], step_out.qbit};
        cnt_nxt = cnt_r + CB'(1);
      end
      mau_pkg::ST_LOAD_Q: begin
        rem_nxt  = acc_r;
        sh_nxt   = {sh_r[VB-1:0], {(BB - VB){1'b0}}};
        y_nxt    = ev_r;
        acc_nxt  = '0;
        cnt_nxt  = '0;
        mret_nxt = mau_pkg::MR_INV;
      end
      mau_pkg::ST_MUL_END: begin
        acc_nxt = '0;
        cnt_nxt = '0;
        case (mret_r)
          mau_pkg::MR_RESULT: begin
            out_valid_nxt  = 1'b1;
            out_result_nxt = acc_r;
          end
          mau_pkg::MR_INV: begin
            // The product q*v is consumed by the coefficient update next cycle.
            acc_nxt = acc_r;
          end
          mau_pkg::MR_POW_RET: begin
            pret_nxt = acc_r;
            sh_nxt   = {pmul_r, {(BB - VB){1'b0}}};
            y_nxt    = pmul_r;
            mret_nxt = mau_pkg::MR_POW_SQ;
          end
          mau_pkg::MR_POW_SQ: begin
            pmul_nxt = acc_r;
            b_nxt    = {1'b0, b_r[BB-1:1]};
          end
          default: begin
          end
        endcase
      end
      mau_pkg::ST_INV_UPD: begin
        // acc_r holds q*v mod m; the new v is u - q*v.
        p_inv   = acc_r;
        eu_nxt  = ev_r;
        ev_nxt  = add_mod(eu_r, modulus - p_inv, modulus);
        acc_nxt = '0;
        cnt_nxt = '0;
        if (rem_r == '0) begin
          // The inverse is the coefficient that just moved into u.
          sh_nxt   = {ra_r, {(BB - VB){1'b0}}};
          y_nxt    = ev_r;
          mret_nxt = mau_pkg::MR_RESULT;
        end else begin
          sh_nxt = {eb_r, {(BB - VB){1'b0}}};
          eb_nxt = rem_r;
          y_nxt  = mau_pkg::res_t'(1);
        end
      end
      mau_pkg::ST_POW: begin
        acc_nxt = '0;
        cnt_nxt = '0;
        if (b_r == '0) begin
          out_valid_nxt  = 1'b1;
          out_result_nxt = pret_r;
        end else if (b_r[0]) begin
          sh_nxt   = {pret_r, {(BB - VB){1'b0}}};
          y_nxt    = pmul_r;
          mret_nxt = mau_pkg::MR_POW_RET;
        end else begin
          sh_nxt   = {pmul_r, {(BB - VB){1'b0}}};
          y_nxt    = pmul_r;
          mret_nxt = mau_pkg::MR_POW_SQ;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mau_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      mret_r      <= mau_pkg::MR_RESULT;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      mret_r      <= mret_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r         <= sh_nxt;
    b_r          <= b_nxt;
    op_r         <= op_nxt;
    acc_r        <= acc_nxt;
    y_r          <= y_nxt;
    ra_r         <= ra_nxt;
    rb_r         <= rb_nxt;
    eb_r         <= eb_nxt;
    eu_r         <= eu_nxt;
    ev_r         <= ev_nxt;
    rem_r        <= rem_nxt;
    pret_r       <= pret_nxt;
    pmul_r       <= pmul_nxt;
    out_result_r <= out_result_nxt;
  end

  assign busy       = (state_r != mau_pkg::ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

`ifndef NO_ASSERTIONS
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == mau_pkg::ST_IDLE))
    else $error("result strobe while an item is still in progress");

  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (modulus != '0)) |-> (out_result_r < modulus))
    else $error("result not below the modulus");

  a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == mau_pkg::ST_RED_A) || (state_r == mau_pkg::ST_RED_B) ||
     (state_r == mau_pkg::ST_MUL)) |-> (acc_r < modulus))
    else $error("accumulator left the residue range");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (modulus != '0)) |=> (state_r == mau_pkg::ST_RED_A))
    else $error("accepted item did not start operand reduction");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/modular_arithmetic_unit.sv
// Modular arithmetic unit. An item (action, operand_a, operand_b) is taken
// when start is high and busy is low; busy then stays high until the cycle
// in which the one result is shown on out_result with out_valid high, and
// busy is already low in that cycle. The receiver cannot stall, so the
// result must be captured in that cycle. All work runs through one
// shift-and-reduce unit that handles one bit per cycle. With a nonzero
// modulus every item first reduces a and then b; an add or subtract then
// finishes at dispatch, and multiply adds a modular multiply of the two
// residues. Power squares the base for each exponent bit and multiplies it
// into the result for each set bit. Divide runs extended Euclid, with a
// division and a multiply per step, then a final multiply by a. The modulus
// register is written through cfg_valid and cfg_ready while no item is in
// progress or being taken; a modulus of zero returns 0 in the cycle after
// the item without raising busy.
`timescale 1ns / 1ps
`default_nettype none

module modular_arithmetic_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [mau_pkg::ACT_BITS-1:0]   in_action,
  input  wire logic [mau_pkg::A_BITS-1:0]     in_operand_a,
  input  wire logic signed [mau_pkg::B_BITS-1:0] in_operand_b,
  output logic                                out_valid,
  output logic [mau_pkg::VALUE_BITS-1:0]      out_result,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [mau_pkg::VALUE_BITS-1:0] cfg_modulus
);

  mau_pkg::res_t modulus_r;
  mau_pkg::res_t modulus_nxt;
  logic          core_busy;

  // A write is held off in the cycle an item is taken, so the item sees one modulus.
  assign cfg_ready   = ~core_busy & ~start;
  assign modulus_nxt = (cfg_valid && cfg_ready) ? cfg_modulus : modulus_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= mau_pkg::MODULUS_RESET;
    end else begin
      modulus_r <= modulus_nxt;
    end
  end

  mau_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (core_busy),
    .in_action    (in_action),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .modulus      (modulus_r),
    .out_valid    (out_valid),
    .out_result   (out_result)
  );

  assign busy = core_busy;

endmodule

`default_nettype wire

FILE: tb/tb_modular_arithmetic_unit.sv
`timescale 1ns / 1ps

module tb_modular_arithmetic_unit;

  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 300;
  localparam logic [mau_pkg::ACT_BITS-1:0] ACT_UNUSED_LO = 3'd5;
  localparam logic [mau_pkg::ACT_BITS-1:0] ACT_UNUSED_MID = 3'd6;
  localparam logic [mau_pkg::ACT_BITS-1:0] ACT_UNUSED_HI = 3'd7;
  localparam logic [mau_pkg::B_BITS-1:0] B_MIN = 64'h8000_0000_0000_0000;
  localparam logic [mau_pkg::B_BITS-1:0] B_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [mau_pkg::A_BITS-1:0] A_ALL_ONES = '1;
  localparam mau_pkg::res_t M_TOP = mau_pkg::MODULUS_RESET - 31'd1;

  typedef struct {
    logic [mau_pkg::ACT_BITS-1:0] act;
    logic [mau_pkg::A_BITS-1:0] a;
    logic [mau_pkg::B_BITS-1:0] b;
  } item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [mau_pkg::ACT_BITS-1:0] in_action = '0;
  logic [mau_pkg::A_BITS-1:0] in_operand_a = '0;
  logic signed [mau_pkg::B_BITS-1:0] in_operand_b = '0;
  logic out_valid;
  logic [mau_pkg::VALUE_BITS-1:0] out_result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [mau_pkg::VALUE_BITS-1:0] cfg_modulus = '0;

  item_t pending_items[$];
  mau_pkg::res_t residue_q[$];
  item_t next_item;
  mau_pkg::res_t want_residue;
  mau_pkg::res_t modulus_copy = mau_pkg::MODULUS_RESET;
  int unsigned send_idle_pct = 0;
  int unsigned op_count[8] = '{default: 0};
  int unsigned items_accepted = 0;
  int unsigned results_checked = 0;
  int unsigned modulus_writes = 0;
  int unsigned errors = 0;
  int unsigned quiet_cycles = 0;

  modular_arithmetic_unit DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_action(in_action),
    .in_operand_a(in_operand_a),
    .in_operand_b(in_operand_b),
    .out_valid(out_valid),
    .out_result(out_result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_modulus(cfg_modulus)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Two's complement value folded into [0, m).
  function automatic bit [63:0] fold_signed(bit [63:0] raw, bit [63:0] m);
    bit [63:0] mag;
    bit [63:0] r;
    if (!raw[63]) return raw % m;
    mag = ~raw + 64'd1;
    r = mag % m;
    return (r != 0) ? m - r : 64'd0;
  endfunction

  function automatic bit [63:0] mul_mod(bit [63:0] x, bit [63:0] y, bit [63:0] m);
    return (x * y) % m;
  endfunction

  // Extended Euclid; the Bezout coefficient of x serves as the inverse even
  // when x and m share a factor.
  function automatic bit [63:0] euclid_inverse(bit [63:0] x, bit [63:0] m);
    longint ra, rb, u, v, q, t;
    ra = x;
    rb = m;
    u = 1;
    v = 0;
    while (rb > 0) begin
      q = ra / rb;
      t = ra - q * rb;
      ra = rb;
      rb = t;
      t = u - q * v;
      u = v;
      v = t;
    end
    return fold_signed(u, m);
  endfunction

  function automatic bit [63:0] power_mod(bit [63:0] base, bit [63:0] expo,
                                          bit [63:0] m);
    bit [63:0] acc;
    bit [63:0] sq;
    acc = 64'd1 % m;
    sq = base;
    if (expo[63]) return acc;
    while (expo != 0) begin
      if (expo[0]) acc = mul_mod(acc, sq, m);
      sq = mul_mod(sq, sq, m);
      expo = expo >> 1;
    end
    return acc;
  endfunction

  function automatic mau_pkg::res_t expected_residue(logic [mau_pkg::ACT_BITS-1:0] act,
                                                     logic [mau_pkg::A_BITS-1:0] a_raw,
                                                     logic [mau_pkg::B_BITS-1:0] b_raw,
                                                     mau_pkg::res_t m_reg);
    bit [63:0] m, a, b, r;
    if (m_reg == 0) return '0;
    m = 64'(m_reg);
    a = 64'(a_raw) % m;
    b = fold_signed(b_raw, m);
    case (act)
      mau_pkg::ACT_ADD: begin
        r = a + b;
        if (r >= m) r = r - m;
      end
      mau_pkg::ACT_SUB: begin
        r = a + (m - b);
        if (r >= m) r = r - m;
      end
      mau_pkg::ACT_MUL: r = mul_mod(a, b, m);
      mau_pkg::ACT_DIV: r = mul_mod(a, euclid_inverse(b, m), m);
      mau_pkg::ACT_POW: r = power_mod(a, b_raw, m);
      default: r = a;
    endcase
    return mau_pkg::res_t'(r);
  endfunction

  function automatic item_t random_item(mau_pkg::res_t m_reg);
    item_t it;
    int unsigned sel;
    int unsigned w;
    bit [63:0] m;
    bit [63:0] mag;
    m = 64'(m_reg);
    sel = $urandom_range(0, 99);
    if (sel < 18) it.act = mau_pkg::ACT_ADD;
    else if (sel < 36) it.act = mau_pkg::ACT_SUB;
    else if (sel < 54) it.act = mau_pkg::ACT_MUL;
    else if (sel < 76) it.act = mau_pkg::ACT_DIV;
    else if (sel < 95) it.act = mau_pkg::ACT_POW;
    else it.act = mau_pkg::ACT_BITS'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));

    case ($urandom_range(0, 7))
      0: it.a = '0;
      1: it.a = (m > 1) ? mau_pkg::A_BITS'(m - 1) : '0;
      2: it.a = mau_pkg::A_BITS'($urandom);
      default: it.a = (m != 0) ? mau_pkg::A_BITS'($urandom % m) : mau_pkg::A_BITS'($urandom);
    endcase

    if (it.act == mau_pkg::ACT_POW) begin
      // Long exponents are slow to run, so most stay short.
      w = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 63) : $urandom_range(0, 16);
      mag = (w == 0) ? 64'd0 : ({$urandom, $urandom} >> (64 - w));
      it.b = ($urandom_range(0, 9) == 0) ? -mag : mag;
    end else begin
      case ($urandom_range(0, 9))
        0, 1: it.b = {$urandom, $urandom};
        2: it.b = B_MIN;
        3: it.b = B_MAX;
        4: it.b = m * $urandom_range(0, 5);
        5: it.b = -(m * $urandom_range(1, 3));
        6: it.b = -64'($urandom_range(1, 1000));
        default: it.b = (m != 0) ? 64'($urandom % m) : 64'($urandom);
      endcase
    end
    return it;
  endfunction

  task automatic push_item(logic [mau_pkg::ACT_BITS-1:0] act, logic [mau_pkg::A_BITS-1:0] a,
                           logic [mau_pkg::B_BITS-1:0] b);
    item_t it;
    it.act = act;
    it.a = a;
    it.b = b;
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_items.size() != 0 || start || residue_q.size() != 0);
  endtask

  task automatic write_modulus(mau_pkg::res_t value);
    cfg_modulus <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    modulus_copy = value;
    modulus_writes++;
  endtask

  task automatic run_phase(mau_pkg::res_t m, int unsigned idle_pct, int n);
    write_modulus(m);
    send_idle_pct = idle_pct;
    repeat (n) pending_items.insert(pending_items.size(), random_item(m));
    wait_drained();
  endtask

  // Driver: the item on the ports is accepted when start is high and busy low.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        residue_q.insert(residue_q.size(),
                         expected_residue(in_action, in_operand_a, in_operand_b,
                                          modulus_copy));
        op_count[in_action]++;
        items_accepted++;
      end
      if (!start || !busy) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_item = pending_items.pop_front();
          start <= 1'b1;
          in_action <= next_item.act;
          in_operand_a <= next_item.a;
          in_operand_b <= next_item.b;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: each strobed result is compared with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      results_checked++;
      if (residue_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d", $time, out_result);
        errors++;
      end else begin
        want_residue = residue_q.pop_front();
        if (out_result !== want_residue) begin
          $display("%0t: result mismatch, expected %0d, actual %0d", $time, want_residue,
                   out_result);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
      $display("tb_modular_arithmetic_unit: errors");
      $finish;
    end
  end

  initial begin
    int unsigned unused_codes;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items against the modulus left by reset.
    send_idle_pct = 6;
    push_item(mau_pkg::ACT_ADD, '0, '0);
    push_item(mau_pkg::ACT_ADD, M_TOP, 64'(M_TOP));
    push_item(mau_pkg::ACT_ADD, A_ALL_ONES, B_MAX);
    push_item(mau_pkg::ACT_SUB, '0, 64'd1);
    push_item(mau_pkg::ACT_SUB, M_TOP, -64'd1);
    push_item(mau_pkg::ACT_SUB, 31'd5, B_MIN);
    push_item(mau_pkg::ACT_MUL, M_TOP, 64'(M_TOP));
    push_item(mau_pkg::ACT_MUL, 31'd123456789, -64'(mau_pkg::MODULUS_RESET));
    push_item(mau_pkg::ACT_DIV, 31'd7, '0);
    push_item(mau_pkg::ACT_DIV, 31'd7, 64'(mau_pkg::MODULUS_RESET));
    push_item(mau_pkg::ACT_DIV, M_TOP, 64'd1);
    push_item(mau_pkg::ACT_DIV, 31'd3, 64'(M_TOP));
    push_item(mau_pkg::ACT_DIV, 31'd123456789, -64'd2);
    push_item(mau_pkg::ACT_POW, 31'd3, '0);
    push_item(mau_pkg::ACT_POW, 31'd3, -64'd5);
    push_item(mau_pkg::ACT_POW, '0, '0);
    push_item(mau_pkg::ACT_POW, '0, 64'd10);
    push_item(mau_pkg::ACT_POW, 31'd2, B_MAX);
    push_item(mau_pkg::ACT_POW, M_TOP, B_MIN);
    push_item(mau_pkg::ACT_POW, A_ALL_ONES, 64'd1000);
    push_item(ACT_UNUSED_LO, A_ALL_ONES, '0);
    push_item(ACT_UNUSED_MID, 31'd12345, -64'd1);
    push_item(ACT_UNUSED_HI, M_TOP, '1);
    wait_drained();

    // A modulus of zero or one and a composite one are corner settings.
    run_phase(mau_pkg::MODULUS_RESET, 0, 120);
    run_phase(31'd2, 80, 60);
    run_phase(31'h7FFF_FFFF, 6, 120);
    run_phase(31'd0, 0, 30);
    run_phase(31'd1, 80, 30);
    run_phase(31'd1000000007, 80, 100);
    run_phase(31'd720720, 0, 100);
    run_phase(31'd97, 6, 60);
    run_phase(mau_pkg::res_t'($urandom_range(2, 32'h7FFF_FFFF)), 80, 100);
    run_phase(31'd3, 0, 40);
    run_phase(mau_pkg::MODULUS_RESET, 6, 90);

    repeat (SETTLE_CYCLES) @(posedge clk);

    unused_codes = 0;
    for (int k = ACT_UNUSED_LO; k <= ACT_UNUSED_HI; k++) unused_codes += op_count[k];
    $display("%0d items over %0d modulus settings: add %0d, sub %0d, mul %0d,",
             items_accepted, modulus_writes + 1, op_count[mau_pkg::ACT_ADD],
             op_count[mau_pkg::ACT_SUB], op_count[mau_pkg::ACT_MUL]);
    $display("  div %0d, pow %0d, other codes %0d; %0d results compared, %0d failures",
             op_count[mau_pkg::ACT_DIV], op_count[mau_pkg::ACT_POW], unused_codes,
             results_checked, errors);
    if (errors == 0) begin
      $display("tb_modular_arithmetic_unit: clean");
    end else begin
      $display("tb_modular_arithmetic_unit: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/mau_pkg.sv
hw/rtl/mau_step.sv
hw/rtl/mau_core.sv
hw/rtl/modular_arithmetic_unit.sv
tb/tb_modular_arithmetic_unit.sv
